// ===== design/sttt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sttt_pkg;

   // table geometry
   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // item field widths
   localparam int CMD_W      = 3;
   localparam int SLOT_FLD_W = 4;
   localparam int DATA_W     = 32;
   localparam int KIND_W     = 2;

   localparam logic [DATA_W-1:0] BLOCKED_MARK = '1;
   localparam logic [DATA_W-1:0] DAY_LIMIT_RST = 32'd86400;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READY  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELAY  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BLOCK  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_PERIOD = 3'd6;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DUE     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

   typedef logic [SLOT_W-1:0] slot_idx_type;

   localparam slot_idx_type LAST_IDX = slot_idx_type'(NUM_SLOTS - 1);

   // sequencer to countdown unit
   typedef struct packed {
      logic init;   // tick accepted: take dt, restart minimum
      logic eval;   // slot on the read port is valid and not blocked
   } alu_ctl_type;

   // countdown unit to sequencer
   typedef struct packed {
      logic due;
      logic blocked;
   } alu_res_type;

   function automatic logic slot_ok(input logic [SLOT_FLD_W-1:0] s);
      return 32'(s) < 32'(NUM_SLOTS);
   endfunction

endpackage

`default_nettype wire

// ===== design/sttt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sttt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/sttt_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sttt_alu (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sttt_pkg::alu_ctl_type         ctl,
   input  wire logic [sttt_pkg::DATA_W-1:0]   now,
   input  wire logic [sttt_pkg::DATA_W-1:0]   day_limit,
   input  wire logic [sttt_pkg::DATA_W-1:0]   rd_time,
   input  wire logic [sttt_pkg::DATA_W-1:0]   rd_period,
   output sttt_pkg::alu_res_type              res,
   output logic      [sttt_pkg::DATA_W-1:0]   t_new,
   output logic      [sttt_pkg::DATA_W-1:0]   min_delay
);

   import sttt_pkg::*;

   logic [DATA_W-1:0] last_time_ff, last_time_in;
   logic [DATA_W-1:0] dt_ff, dt_in;
   logic [DATA_W-1:0] md_ff, md_in;
   logic [DATA_W-1:0] cand_ff, cand_in;
   logic              cand_vld_ff, cand_vld_in;

   logic [DATA_W-1:0] op_a, op_b;
   logic [DATA_W:0]   diff;
   logic [DATA_W-1:0] t_dec;

   // shared subtractor: now - last_time at tick start, time_left - dt per slot
   assign op_a = ctl.init ? now : rd_time;
   assign op_b = ctl.init ? last_time_ff : dt_ff;
   assign diff = {1'b0, op_a} - {1'b0, op_b};

   // count down, clamp at zero; reload a due slot with a nonzero period
   always_comb begin
      t_dec       = diff[DATA_W] ? '0 : diff[DATA_W-1:0];
      res.due     = (t_dec == '0);
      t_new       = (res.due && rd_period != '0) ? rd_period : t_dec;
      res.blocked = (t_new == BLOCKED_MARK);
   end

   // next state
   always_comb begin
      last_time_in = last_time_ff;
      dt_in        = dt_ff;
      md_in        = md_ff;
      cand_in      = t_new;
      cand_vld_in  = ctl.eval && (t_new != '0);
      if (ctl.init) begin
         last_time_in = now;
         dt_in        = diff[DATA_W-1:0];
         md_in        = day_limit - 32'd1;
      end else if (cand_vld_ff && md_ff > cand_ff) begin
         // minimum runs one slot behind the countdown
         md_in = cand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         cand_vld_ff  <= 1'b0;
      end else begin
         last_time_ff <= last_time_in;
         cand_vld_ff  <= cand_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff   <= dt_in;
      md_ff   <= md_in;
      cand_ff <= cand_in;
   end

   assign min_delay = md_ff;

endmodule

`default_nettype wire

// ===== design/software_timer_task_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Timer task table: NUM_SLOTS slots, each with valid, time left and period.
// Input: raise start with req_* fields; the item is taken at an edge where
// start is high and busy is low. busy stays high until all results are out.
// Results come on rsp_* for one cycle each, marked by rsp_valid; the
// receiver must take them as they come (no back-pressure).
// Non-tick commands: one acknowledge, registered in state ST_CMD_ACK after
// ST_CMD_WR and ST_CMD_RD; busy until then, so one command at a time.
// Tick: the slots are walked one per cycle through the shared countdown
// subtractor; the due results come out in slot order as found, and the
// summary (rsp_last high) follows from ST_SUM after the last slot. The
// length of a tick is set by the single read port of the time-left memory
// and one slot per cycle through the unit.
// Configuration: csr_write_enable/csr_write_data write day_limit at once;
// write it only while busy is low and no result is pending.
// Reset: all slots empty, last tick time 0, day_limit 86400, no results.
// Time-left and period memories need no clearing; empty slots go unused.
module software_timer_task_table_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [sttt_pkg::CMD_W-1:0]        req_command,
   input  wire logic [sttt_pkg::SLOT_FLD_W-1:0]   req_slot,
   input  wire logic [sttt_pkg::DATA_W-1:0]       req_now,
   input  wire logic [sttt_pkg::DATA_W-1:0]       req_delay_amount,
   input  wire logic [sttt_pkg::DATA_W-1:0]       req_period_amount,
   // result items
   output logic                                   rsp_valid,
   output logic      [sttt_pkg::KIND_W-1:0]       rsp_kind,
   output logic      [sttt_pkg::SLOT_FLD_W-1:0]   rsp_due_slot,
   output logic      [sttt_pkg::DATA_W-1:0]       rsp_min_delay,
   output logic                                   rsp_slot_present,
   output logic                                   rsp_slot_blocked,
   output logic                                   rsp_last,
   // configuration
   input  wire logic                              csr_write_enable,
   input  wire logic [sttt_pkg::DATA_W-1:0]       csr_write_data
);

   import sttt_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CMD_WR   = 3'd1;
   localparam logic [2:0] ST_CMD_RD   = 3'd2;
   localparam logic [2:0] ST_CMD_ACK  = 3'd3;
   localparam logic [2:0] ST_TICK_RD  = 3'd4;
   localparam logic [2:0] ST_TICK_RUN = 3'd5;
   localparam logic [2:0] ST_SUM_RD   = 3'd6;
   localparam logic [2:0] ST_SUM      = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [DATA_W-1:0]     day_limit_ff, day_limit_in;
   logic [NUM_SLOTS-1:0]  valid_ff, valid_in;
   slot_idx_type          idx_ff, idx_in;

   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [SLOT_FLD_W-1:0] slot_ff, slot_in;
   logic [DATA_W-1:0]     dly_ff, dly_in;
   logic [DATA_W-1:0]     per_ff, per_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [SLOT_FLD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [DATA_W-1:0]     rsp_md_ff, rsp_md_in;
   logic                  rsp_present_ff, rsp_present_in;
   logic                  rsp_blocked_ff, rsp_blocked_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  named_ok;
   slot_idx_type          named_idx;
   logic                  named_present;
   logic                  named_blocked;

   logic                  tl_we, rp_we;
   slot_idx_type          wr_addr, rd_addr;
   logic [DATA_W-1:0]     tl_wdata;
   logic [DATA_W-1:0]     tl_rdata, rp_rdata;

   alu_ctl_type           alu_ctl;
   alu_res_type           alu_res;
   logic [DATA_W-1:0]     alu_t_new;
   logic [DATA_W-1:0]     alu_md;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;

   assign named_ok      = slot_ok(slot_ff);
   assign named_idx     = slot_idx_type'(slot_ff);
   assign named_present = named_ok && valid_ff[named_idx];
   assign named_blocked = named_present && (tl_rdata == BLOCKED_MARK);

   // storage
   sttt_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS)) u_time_left (
      .clock   (clock),
      .wr_en   (tl_we),
      .wr_addr (wr_addr),
      .wr_data (tl_wdata),
      .rd_addr (rd_addr),
      .rd_data (tl_rdata)
   );

   sttt_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS)) u_reload_period (
      .clock   (clock),
      .wr_en   (rp_we),
      .wr_addr (wr_addr),
      .wr_data (per_ff),
      .rd_addr (rd_addr),
      .rd_data (rp_rdata)
   );

   // countdown and minimum unit
   assign alu_ctl.init = accept && (req_command == CMD_TICK);
   assign alu_ctl.eval = (state_ff == ST_TICK_RUN) && valid_ff[idx_ff]
                         && (tl_rdata != BLOCKED_MARK);

   sttt_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .ctl       (alu_ctl),
      .now       (req_now),
      .day_limit (day_limit_ff),
      .rd_time   (tl_rdata),
      .rd_period (rp_rdata),
      .res       (alu_res),
      .t_new     (alu_t_new),
      .min_delay (alu_md)
   );

   // memory ports
   always_comb begin
      tl_we    = 1'b0;
      rp_we    = 1'b0;
      tl_wdata = dly_ff;
      wr_addr  = named_idx;
      rd_addr  = named_idx;
      case (state_ff)
         ST_CMD_WR: begin
            if (named_ok) begin
               case (cmd_ff)
                  CMD_ADD: begin
                     tl_we = 1'b1;
                     rp_we = 1'b1;
                  end
                  CMD_READY: begin
                     tl_we    = 1'b1;
                     tl_wdata = '0;
                  end
                  CMD_DELAY: begin
                     tl_we = 1'b1;
                  end
                  CMD_BLOCK: begin
                     tl_we    = 1'b1;
                     tl_wdata = BLOCKED_MARK;
                  end
                  CMD_PERIOD: begin
                     rp_we = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK_RD: begin
            rd_addr = '0;
         end
         ST_TICK_RUN: begin
            rd_addr  = idx_ff + slot_idx_type'(1);
            wr_addr  = idx_ff;
            tl_we    = alu_ctl.eval;
            tl_wdata = alu_t_new;
         end
         default: begin
         end
      endcase
   end

   // sequencer, slot valid bits and result register
   always_comb begin
      state_in       = state_ff;
      day_limit_in   = csr_write_enable ? csr_write_data : day_limit_ff;
      valid_in       = valid_ff;
      idx_in         = idx_ff;
      cmd_in         = cmd_ff;
      slot_in        = slot_ff;
      dly_in         = dly_ff;
      per_in         = per_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = KIND_ACK;
      rsp_slot_in    = slot_ff;
      rsp_md_in      = '0;
      rsp_present_in = named_present;
      rsp_blocked_in = named_blocked;
      rsp_last_in    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               slot_in  = req_slot;
               dly_in   = req_delay_amount;
               per_in   = req_period_amount;
               idx_in   = '0;
               state_in = (req_command == CMD_TICK) ? ST_TICK_RD : ST_CMD_WR;
            end
         end
         ST_CMD_WR: begin
            if (named_ok && cmd_ff == CMD_ADD) begin
               valid_in[named_idx] = 1'b1;
            end
            if (named_ok && cmd_ff == CMD_REMOVE) begin
               valid_in[named_idx] = 1'b0;
            end
            state_in = ST_CMD_RD;
         end
         ST_CMD_RD: begin
            state_in = ST_CMD_ACK;
         end
         ST_CMD_ACK: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_TICK_RD: begin
            state_in = ST_TICK_RUN;
         end
         ST_TICK_RUN: begin
            // one slot per cycle; due results go out as found
            if (alu_ctl.eval && alu_res.due) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_DUE;
               rsp_slot_in    = SLOT_FLD_W'(idx_ff);
               rsp_present_in = 1'b1;
               rsp_blocked_in = alu_res.blocked;
               rsp_last_in    = 1'b0;
            end
            idx_in = idx_ff + slot_idx_type'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_SUM_RD;
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_SUMMARY;
            rsp_md_in    = alu_md;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         day_limit_ff <= DAY_LIMIT_RST;
         valid_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         day_limit_ff <= day_limit_in;
         valid_ff     <= valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      slot_ff        <= slot_in;
      dly_ff         <= dly_in;
      per_ff         <= per_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_md_ff      <= rsp_md_in;
      rsp_present_ff <= rsp_present_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_due_slot     = rsp_slot_ff;
   assign rsp_min_delay    = rsp_md_ff;
   assign rsp_slot_present = rsp_present_ff;
   assign rsp_slot_blocked = rsp_blocked_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef ASSERT_OFF
   // the final result of an item goes out as the block frees up
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final result while still busy");

   // due results are never final and always name a present slot
   a_due_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DUE |-> !rsp_last && rsp_slot_present)
      else $error("malformed due result");

   // a summary always closes a tick
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SUMMARY |-> rsp_last)
      else $error("summary without last");

   // the slot walk ends after the last slot
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TICK_RUN && idx_ff == LAST_IDX |=> state_ff == ST_SUM_RD)
      else $error("slot walk did not end at last slot");

   // an accepted item makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not start work");
`endif

endmodule

`default_nettype wire

// ===== tb/software_timer_task_table_unit_test.sv =====
`timescale 1ns / 1ps

module software_timer_task_table_unit_test;
   import sttt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;   // unused code, acknowledged only
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 8;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [SLOT_FLD_W-1:0] slot;
      logic [DATA_W-1:0]     min_delay;
      logic                  present;
      logic                  blocked;
      logic                  fin;
   } table_report_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CMD_W-1:0]      req_command;
   logic [SLOT_FLD_W-1:0] req_slot;
   logic [DATA_W-1:0]     req_now;
   logic [DATA_W-1:0]     req_delay_amount;
   logic [DATA_W-1:0]     req_period_amount;
   logic                  rsp_valid;
   logic [KIND_W-1:0]     rsp_kind;
   logic [SLOT_FLD_W-1:0] rsp_due_slot;
   logic [DATA_W-1:0]     rsp_min_delay;
   logic                  rsp_slot_present;
   logic                  rsp_slot_blocked;
   logic                  rsp_last;
   logic                  csr_write_enable;
   logic [DATA_W-1:0]     csr_write_data;

   // shadow of the task table
   logic              shadow_valid [NUM_SLOTS];
   logic [DATA_W-1:0] shadow_left  [NUM_SLOTS];
   logic [DATA_W-1:0] shadow_reload[NUM_SLOTS];
   logic [DATA_W-1:0] shadow_last_tick;
   logic [DATA_W-1:0] shadow_day_limit;

   table_report_type awaited_reports[$];
   int mismatch_count;
   int cycle_count;
   bit steady_send;            // no idle cycles while set
   logic [DATA_W-1:0] clock_now; // timestamp carried by the ticks sent so far

   software_timer_task_table_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_slot          (req_slot),
      .req_now           (req_now),
      .req_delay_amount  (req_delay_amount),
      .req_period_amount (req_period_amount),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_due_slot      (rsp_due_slot),
      .rsp_min_delay     (rsp_min_delay),
      .rsp_slot_present  (rsp_slot_present),
      .rsp_slot_blocked  (rsp_slot_blocked),
      .rsp_last          (rsp_last),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("software_timer_task_table_unit_test NOT OK");
         $finish;
      end
   end

   function automatic void post_report(input logic [KIND_W-1:0] kind,
                                       input logic [SLOT_FLD_W-1:0] slot,
                                       input logic [DATA_W-1:0] md,
                                       input logic present, input logic blocked,
                                       input logic fin);
      table_report_type r;
      r.kind = kind;
      r.slot = slot;
      r.min_delay = md;
      r.present = present;
      r.blocked = blocked;
      r.fin = fin;
      awaited_reports.push_back(r);
   endfunction

   // table update for one accepted item; queues the reports it causes
   function automatic void table_step(input logic [CMD_W-1:0] cmd,
                                      input logic [SLOT_FLD_W-1:0] slot,
                                      input logic [DATA_W-1:0] now,
                                      input logic [DATA_W-1:0] dly,
                                      input logic [DATA_W-1:0] per);
      logic [DATA_W-1:0] dt;
      logic [DATA_W-1:0] md;
      logic [DATA_W-1:0] t;
      logic in_range;
      logic pres;
      in_range = int'(slot) < NUM_SLOTS;
      if (cmd == CMD_TICK) begin
         dt = now - shadow_last_tick;
         md = shadow_day_limit - 32'd1;
         shadow_last_tick = now;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (shadow_valid[i] && shadow_left[i] != BLOCKED_MARK) begin
               t = shadow_left[i];
               if (t != 0)
                  t = (t > dt) ? t - dt : '0;
               if (t == 0) begin
                  if (shadow_reload[i] != 0)
                     t = shadow_reload[i];
                  post_report(KIND_DUE, SLOT_FLD_W'(i), '0, 1'b1, t == BLOCKED_MARK, 1'b0);
               end
               shadow_left[i] = t;
               if (t != 0 && md > t)
                  md = t;
            end
         end
      end else if (in_range) begin
         case (cmd)
            CMD_ADD: begin
               shadow_valid[slot] = 1'b1;
               shadow_left[slot] = dly;
               shadow_reload[slot] = per;
            end
            CMD_REMOVE: shadow_valid[slot] = 1'b0;
            CMD_READY:  shadow_left[slot] = '0;
            CMD_DELAY:  shadow_left[slot] = dly;
            CMD_BLOCK:  shadow_left[slot] = BLOCKED_MARK;
            CMD_PERIOD: shadow_reload[slot] = per;
            default: ;
         endcase
      end
      pres = in_range && shadow_valid[slot];
      post_report((cmd == CMD_TICK) ? KIND_SUMMARY : KIND_ACK, slot,
                  (cmd == CMD_TICK) ? md : '0, pres,
                  pres && shadow_left[slot] == BLOCKED_MARK, 1'b1);
   endfunction

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // result checker: every strobed item against the oldest prediction
   always @(posedge clock) begin : report_check
      table_report_type want;
      if (!reset && rsp_valid) begin
         if (awaited_reports.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual kind %0d slot %0d",
                     $time, rsp_kind, rsp_due_slot);
         end else begin
            want = awaited_reports.pop_front();
            check_field("kind", DATA_W'(want.kind), DATA_W'(rsp_kind));
            check_field("due_slot", DATA_W'(want.slot), DATA_W'(rsp_due_slot));
            check_field("min_delay", want.min_delay, rsp_min_delay);
            check_field("slot_present", DATA_W'(want.present), DATA_W'(rsp_slot_present));
            check_field("slot_blocked", DATA_W'(want.blocked), DATA_W'(rsp_slot_blocked));
            check_field("last", DATA_W'(want.fin), DATA_W'(rsp_last));
         end
      end
   end

   // one item: optional idle cycles, then hold start until accepted
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_FLD_W-1:0] slot,
                            input logic [DATA_W-1:0] now, input logic [DATA_W-1:0] dly,
                            input logic [DATA_W-1:0] per);
      @(negedge clock);
      if (!steady_send) begin
         while ($urandom_range(0, 99) < 35) begin
            start = 1'b0;
            req_command = CMD_W'($urandom);
            req_now = $urandom;
            @(negedge clock);
         end
      end
      start = 1'b1;
      req_command = cmd;
      req_slot = slot;
      req_now = now;
      req_delay_amount = dly;
      req_period_amount = per;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      if (cmd == CMD_TICK)
         clock_now = now;
      table_step(cmd, slot, now, dly, per);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (awaited_reports.size() != 0 || busy)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // day_limit write, only with the block idle
   task automatic write_day_limit(input logic [DATA_W-1:0] value);
      wait_idle();
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data = $urandom;
      shadow_day_limit = value;
   endtask

   function automatic logic [DATA_W-1:0] pick_amount();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return DATA_W'($urandom_range(0, 60));
      if (r < 80) return '0;
      if (r < 88) return BLOCKED_MARK;
      return $urandom;
   endfunction

   task automatic test_empty_tick();
      send_item(CMD_TICK, 4'd0, 32'd0, $urandom, $urandom);
      send_item(CMD_TICK, 4'd9, 32'd100, $urandom, $urandom);
   endtask

   task automatic test_slot_commands();
      send_item(CMD_ADD, 4'd3, $urandom, 32'd40, 32'd0);
      send_item(CMD_ADD, 4'd3, $urandom, 32'd7, 32'd9);     // overwrite occupied slot
      send_item(CMD_REMOVE, 4'd3, $urandom, $urandom, $urandom);
      send_item(CMD_REMOVE, 4'd3, $urandom, $urandom, $urandom); // already empty
      // field writes on an empty slot
      send_item(CMD_READY, 4'd3, $urandom, $urandom, $urandom);
      send_item(CMD_DELAY, 4'd3, $urandom, 32'd12, $urandom);
      send_item(CMD_BLOCK, 4'd3, $urandom, $urandom, $urandom);
      send_item(CMD_PERIOD, 4'd3, $urandom, $urandom, 32'd5);
      send_item(CMD_SPARE, 4'd3, $urandom, $urandom, $urandom);
      send_item(CMD_ADD, 4'd15, $urandom, BLOCKED_MARK, BLOCKED_MARK);
   endtask

   task automatic test_tick_cases();
      send_item(CMD_ADD, 4'd0, $urandom, 32'd0, 32'd0);       // ready one-shot
      send_item(CMD_ADD, 4'd1, $urandom, 32'd5, 32'd3);
      send_item(CMD_ADD, 4'd2, $urandom, 32'd10, BLOCKED_MARK);
      send_item(CMD_TICK, 4'd1, 32'd104, $urandom, $urandom);
      send_item(CMD_TICK, 4'd2, 32'd112, $urandom, $urandom); // reload into blocked
      send_item(CMD_TICK, 4'd15, BLOCKED_MARK, $urandom, $urandom);
      send_item(CMD_TICK, 4'd1, 32'd0, $urandom, $urandom);   // timestamp wraps
      send_item(CMD_DELAY, 4'd1, $urandom, BLOCKED_MARK, $urandom);
      send_item(CMD_PERIOD, 4'd0, $urandom, $urandom, BLOCKED_MARK);
      send_item(CMD_READY, 4'd0, $urandom, $urandom, $urandom);
      send_item(CMD_TICK, 4'd0, 32'd3, $urandom, $urandom);
   endtask

   task automatic test_day_limit_extremes();
      write_day_limit('0);
      send_item(CMD_TICK, 4'd4, 32'd5, $urandom, $urandom);
      write_day_limit(32'd1);
      send_item(CMD_TICK, 4'd4, 32'd6, $urandom, $urandom);
      write_day_limit(BLOCKED_MARK);
      send_item(CMD_TICK, 4'd4, 32'd7, $urandom, $urandom);
   endtask

   // random schedule: mostly ticks and adds, small time steps so tasks fall due
   task automatic test_random_schedule();
      logic [DATA_W-1:0] limits[4];
      logic [DATA_W-1:0] now;
      logic [CMD_W-1:0] cmd;
      int r;
      limits[0] = DATA_W'($urandom_range(1, 100));
      limits[1] = BLOCKED_MARK;
      limits[2] = $urandom;
      limits[3] = DAY_LIMIT_RST;
      for (int seg = 0; seg < 4; seg++) begin
         write_day_limit(limits[seg]);
         steady_send = (seg == 2);
         for (int n = 0; n < 75; n++) begin
            r = $urandom_range(0, 99);
            now = ($urandom_range(0, 99) < 5) ? $urandom
                                               : clock_now + $urandom_range(0, 40);
            if (r < 35) cmd = CMD_TICK;
            else if (r < 60) cmd = CMD_ADD;
            else if (r < 68) cmd = CMD_REMOVE;
            else if (r < 76) cmd = CMD_READY;
            else if (r < 84) cmd = CMD_DELAY;
            else if (r < 90) cmd = CMD_BLOCK;
            else if (r < 96) cmd = CMD_PERIOD;
            else cmd = CMD_SPARE;
            send_item(cmd, SLOT_FLD_W'($urandom), now, pick_amount(), pick_amount());
         end
         steady_send = 1'b0;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_TICK;
      req_slot = '0;
      req_now = '0;
      req_delay_amount = '0;
      req_period_amount = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      mismatch_count = 0;
      cycle_count = 0;
      steady_send = 1'b0;
      clock_now = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_left[i] = '0;
         shadow_reload[i] = '0;
      end
      shadow_last_tick = '0;
      shadow_day_limit = DAY_LIMIT_RST;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_tick();
      test_slot_commands();
      test_tick_cases();
      test_day_limit_extremes();
      test_random_schedule();

      wait_idle();
      if (mismatch_count == 0 && awaited_reports.size() == 0) begin
         $display("software_timer_task_table_unit_test OK");
      end else begin
         $display("software_timer_task_table_unit_test NOT OK");
      end
      $finish;
   end

endmodule
